// ===== hw/rtl/tdm_pkg.sv =====
// Shared types, constants and helper functions for the tank drive mixer.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.

package tdm_pkg;

  // default build values
  localparam int CHANNEL_BITS_DEF = 12;
  localparam int SPEED_SHIFT_DEF  = 6;

  // fixed field widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TIME_W     = 32;
  localparam int SPEED_W    = 8;
  localparam int GAIN_W     = 8;
  localparam int STEP_W     = 7;
  localparam int FAILSAFE_W = 16;
  localparam int GAIN_FRAC  = 4;    // turn gain is unsigned Q4.4
  localparam int SPEED_MAX  = 127;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER    = 3'd0,
    REG_LOW       = 3'd1,
    REG_HIGH      = 3'd2,
    REG_MIN       = 3'd3,
    REG_MAX       = 3'd4,
    REG_TURN_GAIN = 3'd5,
    REG_ACCEL     = 3'd6,
    REG_FAILSAFE  = 3'd7
  } cfg_reg_t;

  // motor direction codes
  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BACK = 2'd2
  } dir_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MUL,
    S_DIV_START,
    S_DIV_WAIT,
    S_TARGET,
    S_COMMIT
  } state_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // saturate a magnitude to the speed range and apply the sign
  function automatic logic signed [SPEED_W-1:0] sat_speed(input logic [31:0] mag,
                                                           input logic neg);
    logic [SPEED_W-1:0] v;
    begin
      v = (mag > 32'(SPEED_MAX)) ? SPEED_W'(SPEED_MAX) : {1'b0, mag[SPEED_W-2:0]};
      return neg ? $signed(-v) : $signed(v);
    end
  endfunction

  // direction code of a signed speed
  function automatic dir_t dir_of(input logic signed [SPEED_W-1:0] s);
    begin
      if (s > 0) return DIR_FWD;
      else if (s < 0) return DIR_BACK;
      else return DIR_STOP;
    end
  endfunction

  // seven-bit magnitude of a signed speed
  function automatic logic [SPEED_W-2:0] mag7(input logic signed [SPEED_W-1:0] s);
    logic [SPEED_W-1:0] a;
    begin
      a = s[SPEED_W-1] ? $unsigned(-s) : $unsigned(s);
      return a[SPEED_W-2:0];
    end
  endfunction

endpackage

// ===== hw/rtl/tdm_divider.sv =====
// Bit-serial restoring divider: one quotient bit per clock.
// Depends on tdm_pkg (div_stat_t).

module tdm_divider #(
  parameter int DVD_W = 2 * tdm_pkg::CHANNEL_BITS_DEF,
  parameter int DVS_W = tdm_pkg::CHANNEL_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DVD_W-1:0]    dividend,
  input  logic [DVS_W-1:0]    divisor,
  output tdm_pkg::div_stat_t  stat,
  output logic [DVD_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] work;   // dividend shifts out, quotient shifts in
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;
  logic [DVS_W-1:0] rem_next;

  // one restoring step
  always_comb begin
    trial    = {rem, work[DVD_W-1]};
    diff     = trial - {1'b0, dvs};
    fits     = trial >= {1'b0, dvs};
    rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      work <= {work[DVD_W-2:0], fits};
      rem  <= rem_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = work;

  // checks
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held for more than one cycle");
  a_done_free: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
  a_busy_src: assert property (@(posedge clk) disable iff (rst) $rose(busy) |-> $past(start))
    else $error("divider became busy without a start");

endmodule

// ===== hw/rtl/tdm_slew.sv =====
// Slew limiter for one track: steps the held speed toward its target,
// stopping at zero when the sign would flip. Depends on tdm_pkg (widths).

module tdm_slew (
  input  logic signed [tdm_pkg::SPEED_W-1:0] target,
  input  logic signed [tdm_pkg::SPEED_W-1:0] current,
  input  logic        [tdm_pkg::STEP_W-1:0]  step,
  output logic signed [tdm_pkg::SPEED_W-1:0] updated
);

  localparam int W = tdm_pkg::SPEED_W + 2;

  logic signed [W-1:0] t;
  logic signed [W-1:0] c;
  logic signed [W-1:0] a;
  logic signed [W-1:0] up;
  logic signed [W-1:0] down;
  logic signed [W-1:0] res;

  always_comb begin
    t    = W'(target);
    c    = W'(current);
    a    = $signed({{(W-tdm_pkg::STEP_W){1'b0}}, step});
    up   = c + a;
    down = c - a;
    res  = t;
    if (t > c) begin
      // rising; clamp at zero when coming up from reverse
      if (t > 0 && c < 0) res = (up > 0) ? '0 : up;
      else res = ((t - c) > a) ? up : t;
    end else if (t < c) begin
      // falling; clamp at zero when coming down from forward
      if (t < 0 && c > 0) res = (down < 0) ? '0 : down;
      else res = ((c - t) > a) ? down : t;
    end
    updated = res[tdm_pkg::SPEED_W-1:0];
  end

endmodule

// ===== hw/rtl/tank_drive_mixer_slew_limited.sv =====
// Top level of the tank drive mixer: configuration registers, sequencer and datapath.
// Depends on tdm_pkg, tdm_divider and tdm_slew.

// Takes one beat at a time: a control packet (command 0) carries throttle and steering and,
// unless its timestamp is zero or repeats the last one, yields one beat of slew-limited left
// and right track speeds; a time tick (command 1) yields a failsafe stop beat only once
// packets are older than failsafe_ms while both tracks run, and nothing otherwise. A packet
// that scales the inner track (throttle in the forward or back band, steering off centre)
// runs its steering ratio through the bit-serial divider, one quotient bit per clock; other
// packets go from decode through multiply and target to commit without it, a stopping tick
// goes from decode straight to commit, and a dropped packet or other tick returns to idle
// after decode. item_stall is low only between items; a finished beat waits in the
// output register while result_stall is high, and the next item can be taken meanwhile,
// though that item's own beat is held until the register frees. Configuration is taken
// when idle.

module tank_drive_mixer_slew_limited #(
  parameter int CHANNEL_BITS = tdm_pkg::CHANNEL_BITS_DEF,
  parameter int SPEED_SHIFT  = tdm_pkg::SPEED_SHIFT_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [tdm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [tdm_pkg::CFG_DATA_W-1:0]         cfg_data,
  // items
  input  logic                                   item_valid,
  output logic                                   item_stall,
  input  logic                                   command,
  input  logic [tdm_pkg::TIME_W-1:0]             time_ms,
  input  logic [CHANNEL_BITS-1:0]                moving_channel,
  input  logic [CHANNEL_BITS-1:0]                direction_channel,
  // results
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic signed [tdm_pkg::SPEED_W-1:0]     left_speed,
  output logic signed [tdm_pkg::SPEED_W-1:0]     right_speed,
  output logic [1:0]                             left_dir,
  output logic [1:0]                             right_dir,
  output logic [tdm_pkg::SPEED_W-2:0]            left_byte,
  output logic [tdm_pkg::SPEED_W-1:0]            right_byte,
  output logic                                   was_failsafe
);

  localparam int CB = CHANNEL_BITS;
  localparam int SW = CB + 2;           // signed working width for channel sums
  localparam int PW = 2 * CB;           // product width
  localparam int CENTER_RST = 1 << (CB - 1);
  localparam int BAND_RST   = 1 << (CB - 5);
  localparam int SPW = tdm_pkg::SPEED_W;

  // configuration registers
  logic [CB-1:0]                     stick_centre;
  logic [CB-1:0]                     dead_lo;
  logic [CB-1:0]                     dead_hi;
  logic [CB-1:0]                     travel_min;
  logic [CB-1:0]                     travel_max;
  logic [tdm_pkg::GAIN_W-1:0]        turn_gain;
  logic [tdm_pkg::STEP_W-1:0]        accel_step;
  logic [tdm_pkg::FAILSAFE_W-1:0]    failsafe_ms;

  // sequencer and held state
  tdm_pkg::state_t                   state;
  tdm_pkg::state_t                   state_next;
  logic [tdm_pkg::TIME_W-1:0]        last_packet_time;

  // captured item
  logic                              cmd;
  logic [tdm_pkg::TIME_W-1:0]        stamp;
  logic [CB-1:0]                     moving;
  logic [CB-1:0]                     steer;

  // decoded operands
  logic                              neg_m;
  logic [CB-1:0]                     abs_m;
  logic                              outer;
  logic                              left_in;
  logic                              right_in;
  logic                              need_div;
  logic [CB-1:0]                     op_a;
  logic [CB-1:0]                     op_b;
  logic [PW-1:0]                     product;
  logic                              fs;
  logic signed [SPW-1:0]             tgt_l;
  logic signed [SPW-1:0]             tgt_r;

  // handshake and control strobes
  logic                              accept;
  logic                              out_free;
  logic                              div_start;
  logic                              commit;

  // decode logic
  logic signed [SW-1:0] mv_s, dr_s, ctr_s, lo_s, hi_s, min_s, max_s;
  logic signed [SW-1:0] m_s, abs_s, span_s, num_raw, num_c, off_s;
  logic                 d_outer, d_fwd, d_left, d_right, d_need_div;
  logic                 pkt_ok, fs_hit;
  logic [tdm_pkg::TIME_W-1:0] age;

  // target logic
  logic signed [SPW-1:0] full_v, scal_v, side_v, piv_v, l_calc, r_calc;
  logic signed [SPW-1:0] slew_l, slew_r;

  // divider
  tdm_pkg::div_stat_t    div_stat;
  logic [PW-1:0]         quotient;

  assign accept   = item_valid && !item_stall;
  assign out_free = !result_valid || !result_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      stick_centre <= CB'(CENTER_RST);
      dead_lo      <= CB'(CENTER_RST - BAND_RST);
      dead_hi      <= CB'(CENTER_RST + BAND_RST);
      travel_min   <= '0;
      travel_max   <= '1;
      turn_gain    <= tdm_pkg::GAIN_W'(16);
      accel_step   <= tdm_pkg::STEP_W'(4);
      failsafe_ms  <= tdm_pkg::FAILSAFE_W'(500);
    end else if (cfg_valid && cfg_ready) begin
      case (tdm_pkg::cfg_reg_t'(cfg_index))
        tdm_pkg::REG_CENTER:    stick_centre <= cfg_data[CB-1:0];
        tdm_pkg::REG_LOW:       dead_lo      <= cfg_data[CB-1:0];
        tdm_pkg::REG_HIGH:      dead_hi      <= cfg_data[CB-1:0];
        tdm_pkg::REG_MIN:       travel_min   <= cfg_data[CB-1:0];
        tdm_pkg::REG_MAX:       travel_max   <= cfg_data[CB-1:0];
        tdm_pkg::REG_TURN_GAIN: turn_gain    <= cfg_data[tdm_pkg::GAIN_W-1:0];
        tdm_pkg::REG_ACCEL:     accel_step   <= cfg_data[tdm_pkg::STEP_W-1:0];
        tdm_pkg::REG_FAILSAFE:  failsafe_ms  <= cfg_data[tdm_pkg::FAILSAFE_W-1:0];
        default: ;
      endcase
    end
  end

  // band decode of the captured item
  always_comb begin
    mv_s  = $signed({2'b00, moving});
    dr_s  = $signed({2'b00, steer});
    ctr_s = $signed({2'b00, stick_centre});
    lo_s  = $signed({2'b00, dead_lo});
    hi_s  = $signed({2'b00, dead_hi});
    min_s = $signed({2'b00, travel_min});
    max_s = $signed({2'b00, travel_max});

    d_fwd   = mv_s >= hi_s;
    d_outer = d_fwd || (mv_s <= lo_s);
    m_s     = d_fwd ? (mv_s - ctr_s) : (mv_s - lo_s);
    abs_s   = (m_s < 0) ? -m_s : m_s;
    d_left  = dr_s < lo_s;
    d_right = dr_s > hi_s;
    span_s  = lo_s - min_s;

    // steering numerator, clamped into the span
    num_raw = d_left ? (dr_s - min_s) : (max_s - dr_s);
    if (num_raw < 0) num_c = '0;
    else if (num_raw > span_s) num_c = span_s;
    else num_c = num_raw;

    off_s      = d_left ? (lo_s - dr_s) : (dr_s - hi_s);
    d_need_div = d_outer && (d_left || d_right) && (span_s > 0);

    age    = stamp - last_packet_time;
    pkt_ok = !cmd && (stamp != '0) && (stamp != last_packet_time);
    fs_hit = cmd && (last_packet_time != '0) && (left_speed != 0) && (right_speed != 0)
             && (age > tdm_pkg::TIME_W'(failsafe_ms));
  end

  // target speeds from product / quotient
  always_comb begin
    full_v = tdm_pkg::sat_speed(32'(abs_m >> SPEED_SHIFT), neg_m);
    scal_v = tdm_pkg::sat_speed(32'(quotient >> SPEED_SHIFT), neg_m);
    side_v = need_div ? scal_v : full_v;
    piv_v  = tdm_pkg::sat_speed(32'(product >> (tdm_pkg::GAIN_FRAC + SPEED_SHIFT)), 1'b0);
    if (outer) begin
      l_calc = left_in ? side_v : full_v;
      r_calc = (!left_in && right_in) ? side_v : full_v;
    end else if (left_in) begin
      l_calc = -piv_v;
      r_calc = piv_v;
    end else if (right_in) begin
      l_calc = piv_v;
      r_calc = -piv_v;
    end else begin
      l_calc = '0;
      r_calc = '0;
    end
  end

  // shared divider for the inner track ratio
  tdm_divider #(
    .DVD_W (PW),
    .DVS_W (CB)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (dead_lo - travel_min),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // slew limit per track
  tdm_slew u_slew_l (
    .target  (tgt_l),
    .current (left_speed),
    .step    (accel_step),
    .updated (slew_l)
  );

  tdm_slew u_slew_r (
    .target  (tgt_r),
    .current (right_speed),
    .step    (accel_step),
    .updated (slew_r)
  );

  // sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      tdm_pkg::S_IDLE:      if (item_valid) state_next = tdm_pkg::S_DECODE;
      tdm_pkg::S_DECODE: begin
        if (pkt_ok) state_next = tdm_pkg::S_MUL;
        else if (fs_hit) state_next = tdm_pkg::S_COMMIT;
        else state_next = tdm_pkg::S_IDLE;
      end
      tdm_pkg::S_MUL:       state_next = need_div ? tdm_pkg::S_DIV_START : tdm_pkg::S_TARGET;
      tdm_pkg::S_DIV_START: state_next = tdm_pkg::S_DIV_WAIT;
      tdm_pkg::S_DIV_WAIT:  if (div_stat.done) state_next = tdm_pkg::S_TARGET;
      tdm_pkg::S_TARGET:    state_next = tdm_pkg::S_COMMIT;
      tdm_pkg::S_COMMIT:    if (out_free) state_next = tdm_pkg::S_IDLE;
      default:              state_next = tdm_pkg::S_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    item_stall = 1'b1;
    cfg_ready  = 1'b0;
    div_start  = 1'b0;
    commit     = 1'b0;
    case (state)
      tdm_pkg::S_IDLE: begin
        item_stall = 1'b0;
        cfg_ready  = 1'b1;
      end
      tdm_pkg::S_DIV_START: div_start = 1'b1;
      tdm_pkg::S_COMMIT:    commit = out_free;
      default: ;
    endcase
  end

  // control state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= tdm_pkg::S_IDLE;
      result_valid     <= 1'b0;
      left_speed       <= '0;
      right_speed      <= '0;
      was_failsafe     <= 1'b0;
      last_packet_time <= '0;
    end else begin
      state <= state_next;
      if (commit) begin
        result_valid <= 1'b1;
        left_speed   <= fs ? '0 : slew_l;
        right_speed  <= fs ? '0 : slew_r;
        was_failsafe <= fs;
        if (!fs) last_packet_time <= stamp;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd    <= command;
      stamp  <= time_ms;
      moving <= moving_channel;
      steer  <= direction_channel;
    end
    case (state)
      tdm_pkg::S_DECODE: begin
        neg_m    <= m_s < 0;
        abs_m    <= abs_s[CB-1:0];
        outer    <= d_outer;
        left_in  <= d_left;
        right_in <= d_right;
        need_div <= d_need_div;
        op_a     <= d_outer ? abs_s[CB-1:0] : off_s[CB-1:0];
        op_b     <= d_outer ? num_c[CB-1:0] : CB'(turn_gain);
        fs       <= cmd;
        tgt_l    <= '0;
        tgt_r    <= '0;
      end
      tdm_pkg::S_MUL:    product <= op_a * op_b;
      tdm_pkg::S_TARGET: begin
        tgt_l <= l_calc;
        tgt_r <= r_calc;
      end
      default: ;
    endcase
  end

  // result fields derived from the held speeds
  assign left_dir   = tdm_pkg::dir_of(left_speed);
  assign right_dir  = tdm_pkg::dir_of(right_speed);
  assign left_byte  = tdm_pkg::mag7(left_speed);
  assign right_byte = {1'b1, tdm_pkg::mag7(right_speed)};

  // checks
  a_fs_zero: assert property (@(posedge clk) disable iff (rst)
      result_valid && was_failsafe |-> left_speed == 0 && right_speed == 0)
    else $error("failsafe beat with a running track");
  a_no_min: assert property (@(posedge clk) disable iff (rst)
      result_valid |-> left_speed[SPW-1:0] != 8'h80 && right_speed[SPW-1:0] != 8'h80)
    else $error("track speed out of range");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
      state == tdm_pkg::S_TARGET |-> !div_stat.busy)
    else $error("target taken while divider still running");
  a_commit: assert property (@(posedge clk) disable iff (rst)
      commit |=> result_valid && state == tdm_pkg::S_IDLE)
    else $error("committed beat not presented");

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for the tank drive mixer: scripted and random packets and ticks,
// each result beat checked field by field against an in-bench mixer and slew model or a scripted value.
// Depends on tdm_pkg and tank_drive_mixer_slew_limited only.

module tb_top;

  localparam int CB        = tdm_pkg::CHANNEL_BITS_DEF;
  localparam int SHIFT     = tdm_pkg::SPEED_SHIFT_DEF;
  localparam int SPW       = tdm_pkg::SPEED_W;
  localparam int SETTLE    = 2 * CB + 16;   // longest item plus margin
  localparam int PER_PHASE = 72;

  // one result beat as seen on the output ports
  typedef struct packed {
    logic signed [SPW-1:0] l;
    logic signed [SPW-1:0] r;
    tdm_pkg::dir_t         ld;
    tdm_pkg::dir_t         rd;
    logic [SPW-2:0]        lb;
    logic [SPW-1:0]        rb;
    logic                  fs;
  } drive_beat_t;

  // scripted rows: checked by the model, typed result, typed silence, register write
  typedef enum {R_ITEM, R_TYPED, R_SILENT, R_CFG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic              cmd;
    tdm_pkg::cfg_reg_t ridx;
    logic [31:0]       tval;     // time, or write data for a register row
    logic [CB-1:0]     mv;
    logic [CB-1:0]     dr;
    int                exp_l;
    int                exp_r;
    logic              exp_fs;
  } row_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [tdm_pkg::CFG_IDX_W-1:0]  cfg_index = tdm_pkg::REG_CENTER;
  logic [tdm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           item_valid = 1'b0;
  logic                           item_stall;
  logic                           command = 1'b0;
  logic [tdm_pkg::TIME_W-1:0]     time_ms = '0;
  logic [CB-1:0]                  moving_channel = '0;
  logic [CB-1:0]                  direction_channel = '0;
  logic                           result_valid;
  logic                           result_stall = 1'b0;
  logic signed [SPW-1:0]          left_speed;
  logic signed [SPW-1:0]          right_speed;
  logic [1:0]                     left_dir;
  logic [1:0]                     right_dir;
  logic [SPW-2:0]                 left_byte;
  logic [SPW-1:0]                 right_byte;
  logic                           was_failsafe;

  // model copy of the registers and track state, at reset values
  int unsigned p_center = 2048, p_low = 1920, p_high = 2176, p_min = 0, p_max = 4095;
  int unsigned p_gain = 16, p_step = 4, p_fs = 500;
  logic [31:0] seen_ms = '0;
  int          trk_l = 0, trk_r = 0;

  drive_beat_t pending_speeds[$];
  bit          quiet = 1'b0;
  logic [31:0] clock_ms = 32'd5000;
  int          mismatches = 0, items_sent = 0, beats_seen = 0, stops_seen = 0;
  int          settings_used = 0;

  tank_drive_mixer_slew_limited i_dut (
    .clk, .rst,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .item_valid, .item_stall, .command, .time_ms, .moving_channel, .direction_channel,
    .result_valid, .result_stall, .left_speed, .right_speed, .left_dir, .right_dir,
    .left_byte, .right_byte, .was_failsafe
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- model

  function automatic int clip127(longint unsigned mag, bit neg);
    int v;
    v = (mag > 127) ? 127 : int'(mag);
    return neg ? -v : v;
  endfunction

  // inner track: |m| * num / span, clamped ratio, sign of m kept
  function automatic int inner_track(int m, int num, int span);
    bit neg;
    longint unsigned mag;
    neg = m < 0;
    mag = neg ? -m : m;
    if (span > 0) begin
      if (num < 0) num = 0;
      if (num > span) num = span;
      mag = mag * num / span;
    end
    return clip127(mag >> SHIFT, neg);
  endfunction

  function automatic int spin(int offset, bit neg);
    return clip127((longint'(offset) * p_gain) >> (tdm_pkg::GAIN_FRAC + SHIFT), neg);
  endfunction

  // step toward target, stopping at zero when the sign flips
  function automatic int ramp(int target, int old);
    int a;
    a = int'(p_step);
    if (target > old) begin
      if (target > 0 && old < 0) return (old + a > 0) ? 0 : old + a;
      return (target - old > a) ? old + a : target;
    end
    if (target < old) begin
      if (target < 0 && old > 0) return (old - a < 0) ? 0 : old - a;
      return (old - target > a) ? old - a : target;
    end
    return target;
  endfunction

  function automatic drive_beat_t make_beat(int l, int r, logic fs);
    drive_beat_t b;
    int lm, rm;
    lm = l < 0 ? -l : l;
    rm = r < 0 ? -r : r;
    b.l  = SPW'(l);
    b.r  = SPW'(r);
    b.ld = l > 0 ? tdm_pkg::DIR_FWD : (l < 0 ? tdm_pkg::DIR_BACK : tdm_pkg::DIR_STOP);
    b.rd = r > 0 ? tdm_pkg::DIR_FWD : (r < 0 ? tdm_pkg::DIR_BACK : tdm_pkg::DIR_STOP);
    b.lb = (SPW-1)'(lm);
    b.rb = {1'b1, (SPW-1)'(rm)};
    b.fs = fs;
    return b;
  endfunction

  // advance the model by one item; returns 1 when a beat is due
  function automatic bit mix_and_ramp(logic cmd, logic [31:0] t, logic [CB-1:0] mv_in,
                                      logic [CB-1:0] dr_in, output drive_beat_t beat);
    int mv, dr, lo, hi, span, m, full, l, r;
    logic [31:0] elapsed;
    mv = int'(mv_in);
    dr = int'(dr_in);
    lo = int'(p_low);
    hi = int'(p_high);
    span = lo - int'(p_min);
    beat = '0;
    if (cmd) begin
      elapsed = t - seen_ms;
      if (seen_ms != 0 && trk_l != 0 && trk_r != 0 && elapsed > p_fs) begin
        trk_l = 0;
        trk_r = 0;
        beat = make_beat(0, 0, 1'b1);
        return 1'b1;
      end
      return 1'b0;
    end
    if (t == 0 || t == seen_ms) return 1'b0;
    seen_ms = t;
    if (mv >= hi || mv <= lo) begin
      m = (mv >= hi) ? mv - int'(p_center) : -(lo - mv);
      full = inner_track(m, 1, 1);
      if (dr < lo) begin
        l = inner_track(m, dr - int'(p_min), span);
        r = full;
      end else if (dr > hi) begin
        l = full;
        r = inner_track(m, int'(p_max) - dr, span);
      end else begin
        l = full;
        r = full;
      end
    end else if (dr < lo) begin
      l = spin(lo - dr, 1'b1);
      r = spin(lo - dr, 1'b0);
    end else if (dr > hi) begin
      l = spin(dr - hi, 1'b0);
      r = spin(dr - hi, 1'b1);
    end else begin
      l = 0;
      r = 0;
    end
    trk_l = ramp(l, trk_l);
    trk_r = ramp(r, trk_r);
    beat = make_beat(trk_l, trk_r, 1'b0);
    return 1'b1;
  endfunction

  function automatic void set_reg(tdm_pkg::cfg_reg_t idx, logic [15:0] d);
    case (idx)
      tdm_pkg::REG_CENTER:    p_center = d[CB-1:0];
      tdm_pkg::REG_LOW:       p_low    = d[CB-1:0];
      tdm_pkg::REG_HIGH:      p_high   = d[CB-1:0];
      tdm_pkg::REG_MIN:       p_min    = d[CB-1:0];
      tdm_pkg::REG_MAX:       p_max    = d[CB-1:0];
      tdm_pkg::REG_TURN_GAIN: p_gain   = d[tdm_pkg::GAIN_W-1:0];
      tdm_pkg::REG_ACCEL:     p_step   = d[tdm_pkg::STEP_W-1:0];
      tdm_pkg::REG_FAILSAFE:  p_fs     = d[tdm_pkg::FAILSAFE_W-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_item(logic cmd, logic [31:0] t, logic [CB-1:0] mv, logic [CB-1:0] dr,
                           row_kind_t kind, drive_beat_t typed_beat);
    drive_beat_t pred;
    bit got;
    if (!quiet) begin
      while ($urandom_range(0, 99) < 30) begin
        item_valid <= 1'b0;
        @(posedge clk);
      end
    end
    item_valid        <= 1'b1;
    command           <= cmd;
    time_ms           <= t;
    moving_channel    <= mv;
    direction_channel <= dr;
    do @(posedge clk); while (item_stall);
    got = mix_and_ramp(cmd, t, mv, dr, pred);
    if (kind == R_TYPED) pending_speeds.push_back(typed_beat);
    else if (kind == R_ITEM && got) pending_speeds.push_back(pred);
    items_sent++;
  endtask

  // stop sending and wait for every outstanding beat
  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending_speeds.size() != 0);
  endtask

  // drained, then long enough for a beatless item to finish
  task automatic settle();
    drain();
    repeat (SETTLE) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes need no gap
  task automatic write_reg(tdm_pkg::cfg_reg_t idx, logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    set_reg(idx, d);
  endtask

  function automatic logic [CB-1:0] pick_channel();
    case ($urandom_range(0, 3))
      0: return CB'($urandom);
      1: return CB'($urandom_range(p_low, p_high));
      2: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          2: return CB'(p_low);
          default: return CB'(p_high);
        endcase
      end
      default: return CB'($urandom_range(p_min, p_max));
    endcase
  endfunction

  // mostly fresh packets and ticks around the timeout, some dropped packets and wild items
  task automatic drive_random(int n);
    int kept, pick;
    bit drained;
    logic c;
    logic [31:0] t;
    kept = 0;
    drained = 1'b0;
    while (kept < n) begin
      if (kept == n / 2 && !drained) begin
        drain();
        drained = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        clock_ms += $urandom_range(1, 40);
        if (clock_ms == 0) clock_ms = 1;
        send_item(1'b0, clock_ms, pick_channel(), pick_channel(), R_ITEM, '0);
        kept++;
      end else if (pick < 84) begin
        t = seen_ms + $urandom_range(0, p_fs * 2 + 2);
        send_item(1'b1, t, CB'($urandom), CB'($urandom), R_ITEM, '0);
        kept++;
      end else if (pick < 92) begin
        // zero or repeated stamp: ignored by the block
        t = $urandom_range(0, 1) ? 32'd0 : seen_ms;
        send_item(1'b0, t, pick_channel(), pick_channel(), R_ITEM, '0);
      end else begin
        c = $urandom_range(0, 1);
        t = $urandom;
        if (!c) clock_ms = t;
        send_item(c, t, CB'($urandom), CB'($urandom), R_ITEM, '0);
        kept++;
      end
    end
  endtask

  // ---------------------------------------------------------------- checker

  task automatic report(string what, int want, int got);
    $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_beats
    drive_beat_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_speeds.size() == 0) begin
        $display("%0t: unexpected beat: left %0d right %0d failsafe %0b", $time,
                 left_speed, right_speed, was_failsafe);
        mismatches++;
      end else begin
        want = pending_speeds.pop_front();
        beats_seen++;
        if (want.fs) stops_seen++;
        if (want.l !== left_speed) report("left_speed", want.l, left_speed);
        if (want.r !== right_speed) report("right_speed", want.r, right_speed);
        if (want.ld !== left_dir) report("left_dir", want.ld, left_dir);
        if (want.rd !== right_dir) report("right_dir", want.rd, right_dir);
        if (want.lb !== left_byte) report("left_byte", want.lb, left_byte);
        if (want.rb !== right_byte) report("right_byte", want.rb, right_byte);
        if (want.fs !== was_failsafe) report("was_failsafe", want.fs, was_failsafe);
      end
    end
    result_stall <= !quiet && ($urandom_range(0, 99) < 30);
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    row_t drive_script[$];
    row_t row;
    int unsigned vals [8];
    int mn, lo, hi;
    drive_script = '{
      // nothing heard yet: tick is silent
      '{R_SILENT, 1'b1, tdm_pkg::REG_CENTER, 32'd5, 12'd0, 12'd0, 0, 0, 1'b0},
      // full throttle from rest ramps by one step
      '{R_TYPED, 1'b0, tdm_pkg::REG_CENTER, 32'd1, 12'd4095, 12'd2048, 4, 4, 1'b0},
      // zero stamp and repeated stamp are dropped
      '{R_SILENT, 1'b0, tdm_pkg::REG_CENTER, 32'd0, 12'd4095, 12'd2048, 0, 0, 1'b0},
      '{R_SILENT, 1'b0, tdm_pkg::REG_CENTER, 32'd1, 12'd0, 12'd0, 0, 0, 1'b0},
      // tick within the timeout, then past it, then again with tracks stopped
      '{R_SILENT, 1'b1, tdm_pkg::REG_CENTER, 32'd2, 12'd0, 12'd0, 0, 0, 1'b0},
      '{R_TYPED, 1'b1, tdm_pkg::REG_CENTER, 32'd1000, 12'd0, 12'd0, 0, 0, 1'b1},
      '{R_SILENT, 1'b1, tdm_pkg::REG_CENTER, 32'd2000, 12'd0, 12'd0, 0, 0, 1'b0},
      // full reverse from rest
      '{R_TYPED, 1'b0, tdm_pkg::REG_CENTER, 32'd1001, 12'd0, 12'd2048, -4, -4, 1'b0},
      // stick corners and band edges
      '{R_ITEM, 1'b0, tdm_pkg::REG_CENTER, 32'd1002, 12'd4095, 12'd0, 0, 0, 1'b0},
      '{R_ITEM, 1'b0, tdm_pkg::REG_CENTER, 32'd1003, 12'd4095, 12'd4095, 0, 0, 1'b0},
      '{R_ITEM, 1'b0, tdm_pkg::REG_CENTER, 32'd1004, 12'd0, 12'd0, 0, 0, 1'b0},
      '{R_ITEM, 1'b0, tdm_pkg::REG_CENTER, 32'd1005, 12'd0, 12'd4095, 0, 0, 1'b0},
      '{R_ITEM, 1'b0, tdm_pkg::REG_CENTER, 32'd1006, 12'd2048, 12'd0, 0, 0, 1'b0},
      '{R_ITEM, 1'b0, tdm_pkg::REG_CENTER, 32'd1007, 12'd2048, 12'd4095, 0, 0, 1'b0},
      '{R_ITEM, 1'b0, tdm_pkg::REG_CENTER, 32'd1008, 12'd2048, 12'd2048, 0, 0, 1'b0},
      '{R_ITEM, 1'b0, tdm_pkg::REG_CENTER, 32'd1009, 12'd1920, 12'd1920, 0, 0, 1'b0},
      '{R_ITEM, 1'b0, tdm_pkg::REG_CENTER, 32'd1010, 12'd2176, 12'd2176, 0, 0, 1'b0},
      // top of the time range, then a tick whose age wraps
      '{R_ITEM, 1'b0, tdm_pkg::REG_CENTER, 32'hFFFF_FFFF, 12'd4095, 12'd2048, 0, 0, 1'b0},
      '{R_ITEM, 1'b1, tdm_pkg::REG_CENTER, 32'h0000_0300, 12'd0, 12'd0, 0, 0, 1'b0},
      // big gain and step: pivot saturates, then a sign flip stops at zero
      '{R_CFG, 1'b0, tdm_pkg::REG_ACCEL, 32'd127, 12'd0, 12'd0, 0, 0, 1'b0},
      '{R_CFG, 1'b0, tdm_pkg::REG_TURN_GAIN, 32'd255, 12'd0, 12'd0, 0, 0, 1'b0},
      '{R_ITEM, 1'b0, tdm_pkg::REG_CENTER, 32'h301, 12'd2048, 12'd0, 0, 0, 1'b0},
      '{R_ITEM, 1'b0, tdm_pkg::REG_CENTER, 32'h302, 12'd2048, 12'd4095, 0, 0, 1'b0},
      // centre above the dead band: forward band with throttle below centre
      '{R_CFG, 1'b0, tdm_pkg::REG_CENTER, 32'd2300, 12'd0, 12'd0, 0, 0, 1'b0},
      '{R_ITEM, 1'b0, tdm_pkg::REG_CENTER, 32'h303, 12'd2200, 12'd2048, 0, 0, 1'b0},
      // min above low: empty span, inner track unscaled
      '{R_CFG, 1'b0, tdm_pkg::REG_MIN, 32'd2000, 12'd0, 12'd0, 0, 0, 1'b0},
      '{R_CFG, 1'b0, tdm_pkg::REG_MAX, 32'd4000, 12'd0, 12'd0, 0, 0, 1'b0},
      '{R_ITEM, 1'b0, tdm_pkg::REG_CENTER, 32'h304, 12'd4095, 12'd100, 0, 0, 1'b0},
      // narrow span: steering numerator clamps
      '{R_CFG, 1'b0, tdm_pkg::REG_MIN, 32'd0, 12'd0, 12'd0, 0, 0, 1'b0},
      '{R_CFG, 1'b0, tdm_pkg::REG_LOW, 32'd100, 12'd0, 12'd0, 0, 0, 1'b0},
      '{R_CFG, 1'b0, tdm_pkg::REG_HIGH, 32'd3000, 12'd0, 12'd0, 0, 0, 1'b0},
      '{R_CFG, 1'b0, tdm_pkg::REG_MAX, 32'd4095, 12'd0, 12'd0, 0, 0, 1'b0},
      '{R_ITEM, 1'b0, tdm_pkg::REG_CENTER, 32'h305, 12'd4095, 12'd3001, 0, 0, 1'b0},
      // zero step holds speeds; zero timeout trips on the next tick
      '{R_CFG, 1'b0, tdm_pkg::REG_ACCEL, 32'd0, 12'd0, 12'd0, 0, 0, 1'b0},
      '{R_CFG, 1'b0, tdm_pkg::REG_FAILSAFE, 32'd0, 12'd0, 12'd0, 0, 0, 1'b0},
      '{R_ITEM, 1'b0, tdm_pkg::REG_CENTER, 32'h306, 12'd0, 12'd2048, 0, 0, 1'b0},
      '{R_ITEM, 1'b1, tdm_pkg::REG_CENTER, 32'h307, 12'd0, 12'd0, 0, 0, 1'b0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // scripted part
    for (int k = 0; k < drive_script.size(); k++) begin
      row = drive_script[k];
      if (row.kind == R_CFG) begin
        if (k == 0 || drive_script[k-1].kind != R_CFG) settle();
        write_reg(row.ridx, row.tval[15:0]);
        if (k + 1 == drive_script.size() || drive_script[k+1].kind != R_CFG)
          cfg_valid <= 1'b0;
      end else begin
        send_item(row.cmd, row.tval, row.mv, row.dr, row.kind,
                  make_beat(row.exp_l, row.exp_r, row.exp_fs));
      end
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: vals = '{2048, 1920, 2176, 0, 4095, 16, 4, 500};
        1: vals = '{4095, 4095, 4095, 4095, 4095, 255, 127, 65535};
        2: vals = '{0, 0, 0, 0, 0, 0, 1, 0};
        5: foreach (vals[i]) vals[i] = $urandom_range(0, 65535);
        default: begin
          mn = $urandom_range(0, 800);
          lo = $urandom_range(mn + 1, 2000);
          hi = $urandom_range(lo, 2800);
          vals = '{$urandom_range(lo, hi), lo, hi, mn, $urandom_range(3000, 4095),
                   $urandom_range(0, 255), $urandom_range(1, 127), $urandom_range(0, 300)};
        end
      endcase
      settle();
      quiet = (ph == 3);
      for (int i = 0; i <= tdm_pkg::REG_FAILSAFE; i++)
        write_reg(tdm_pkg::cfg_reg_t'(i), 16'(vals[i]));
      cfg_valid <= 1'b0;
      settings_used++;
      drive_random(PER_PHASE);
    end

    settle();
    $display("Sent %0d packets and ticks under %0d random register settings plus scripted edges;",
             items_sent, settings_used);
    $display("checked %0d speed beats, %0d of them failsafe stops.", beats_seen, stops_seen);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("%0t: run timed out with %0d beats outstanding", $time, pending_speeds.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
